>>> hdl/chbt_pkg.sv
`timescale 1ns / 1ps
package chbt_pkg;

   localparam int MAX_PEERS_DEFAULT = 16;

   localparam logic [19:0] HB_INTERVAL_RESET = 20'd1000;
   localparam logic [19:0] TIMEOUT_RESET     = 20'd10000;
   localparam logic [3:0]  MAX_RETRIES_RESET = 4'd5;

   localparam logic [1:0] CSR_HB_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT     = 2'd1;
   localparam logic [1:0] CSR_MAX_RETRIES = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD         = 3'd0,
      OP_REMOVE_ADDR = 3'd1,
      OP_REMOVE_ID   = 3'd2,
      OP_REPLY       = 3'd3,
      OP_TICK        = 3'd4,
      OP_LOOKUP      = 3'd5,
      OP_DISC_ALL    = 3'd6,
      OP_UNUSED      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      KIND_STATUS    = 2'd0,
      KIND_HEARTBEAT = 2'd1,
      KIND_DISC      = 2'd2,
      KIND_TIMEOUT   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FETCH,
      ST_APPLY,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic [31:0] address;
      logic [15:0] port;
      logic [15:0] ident;
      logic [31:0] last_heard;
      logic [31:0] sent_time;
      logic        waiting;
      logic [3:0]  retries;
      logic [31:0] ping;
   } entry_type;

   typedef struct packed {
      logic quiet;
      logic drop;
      logic send;
   } age_type;

endpackage

>>> hdl/chbt_ram.sv
`timescale 1ns / 1ps
module chbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/chbt_age.sv
`timescale 1ns / 1ps
module chbt_age (
   input  logic                clock,
   input  logic                load,
   input  chbt_pkg::entry_type rec,
   input  logic [31:0]         clock_ms,
   input  logic [19:0]         interval,
   input  logic [19:0]         timeout,
   input  logic [3:0]          max_retries,
   output chbt_pkg::age_type   age
);

   logic [31:0] silence_ff, silence_in;
   logic [24:0] thr_ff, thr_in;
   logic        over_ff, over_in;
   logic        waiting_ff, waiting_in;

   // The heartbeat threshold grows with each unanswered request.
   always_comb begin
      silence_in = clock_ms - rec.last_heard;
      thr_in     = 25'(interval) * 25'({1'b0, rec.retries} + 5'd1);
      over_in    = rec.retries > max_retries;
      waiting_in = rec.waiting;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         silence_ff <= silence_in;
         thr_ff     <= thr_in;
         over_ff    <= over_in;
         waiting_ff <= waiting_in;
      end
   end

   always_comb begin
      age.quiet = silence_ff < 32'(interval);
      age.drop  = (silence_ff >= 32'(timeout)) || over_ff;
      age.send  = !waiting_ff && (silence_ff >= 32'(thr_ff));
   end

endmodule

>>> hdl/client_heartbeat_timeout_table_core.sv
`timescale 1ns / 1ps
// Add, remove, reply and lookup each scan the single entry memory once; reply and lookup
// then fetch the found entry. The result follows in the cycle busy drops. Tick and
// disconnect all rescan once per live peer in id order, then run a final scan.
// An unused code answers in the next cycle.
// One item at a time; the receiver cannot stall; synchronous reset empties the table.
module client_heartbeat_timeout_table_core #(
   parameter int MAX_PEERS = chbt_pkg::MAX_PEERS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_peer_address,
   input  logic [15:0] req_peer_port,
   input  logic [15:0] req_client_id,
   input  logic [15:0] req_elapsed_ms,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_out_client,
   output logic        rsp_ok,
   output logic [31:0] rsp_stamp_ms,
   output logic [31:0] rsp_ping_ms,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CW = $clog2(MAX_PEERS + 1);
   localparam int EW = $bits(chbt_pkg::entry_type);

   chbt_pkg::state_type state_ff, state_in;
   chbt_pkg::op_type    op_ff, op_in;
   logic [31:0]         addr_ff, addr_in;
   logic [15:0]         port_ff, port_in;
   logic [15:0]         cid_ff, cid_in;
   logic [31:0]         clock_ms_ff, clock_ms_in;
   logic [15:0]         next_id_ff, next_id_in;
   logic [19:0]         hi_ff, hi_in;
   logic [19:0]         ct_ff, ct_in;
   logic [3:0]          mr_ff, mr_in;
   logic [MAX_PEERS-1:0] valid_ff, valid_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                rdv_ff, rdv_in;
   logic [AW-1:0]       ridx_ff, ridx_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       fidx_ff, fidx_in;
   logic [15:0]         fid_ff, fid_in;
   logic                first_ff, first_in;
   logic [15:0]         prev_ff, prev_in;
   logic                pend_ff, pend_in;
   chbt_pkg::kind_type  pkind_ff, pkind_in;
   logic [15:0]         pclient_ff, pclient_in;
   logic [31:0]         pstamp_ff, pstamp_in;
   logic                rv_ff, rv_in;
   chbt_pkg::kind_type  rkind_ff, rkind_in;
   logic [15:0]         rclient_ff, rclient_in;
   logic                rok_ff, rok_in;
   logic [31:0]         rstamp_ff, rstamp_in;
   logic [31:0]         rping_ff, rping_in;
   logic                rlast_ff, rlast_in;

   logic                accept;
   logic                scan_done;
   logic                walk_op;
   logic                hit;
   logic                free_any;
   logic [AW-1:0]       free_idx;
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   chbt_pkg::entry_type wr_rec, rec;
   logic [EW-1:0]       rd_data;
   logic                age_load;
   chbt_pkg::age_type   age;

   assign accept    = start && !busy;
   assign busy      = state_ff != chbt_pkg::ST_IDLE;
   assign scan_done = (cnt_ff == CW'(MAX_PEERS)) && !rdv_ff;
   assign walk_op   = (op_ff == chbt_pkg::OP_TICK) || (op_ff == chbt_pkg::OP_DISC_ALL);
   assign rec       = chbt_pkg::entry_type'(rd_data);

   chbt_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_PEERS),
      .AW   (AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(EW'(wr_rec)),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   chbt_age u_age (
      .clock      (clock),
      .load       (age_load),
      .rec        (rec),
      .clock_ms   (clock_ms_ff),
      .interval   (hi_ff),
      .timeout    (ct_ff),
      .max_retries(mr_ff),
      .age        (age)
   );

   // Lowest free slot.
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = MAX_PEERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   // Match test on the entry coming out of the memory during a scan.
   always_comb begin
      logic vld;
      logic key_m;
      vld   = valid_ff[ridx_ff];
      key_m = vld && (rec.address == addr_ff) && (rec.port == port_ff);
      unique case (op_ff) inside
         chbt_pkg::OP_ADD: hit = !found_ff && (key_m || (vld && rec.ident == next_id_ff));
         chbt_pkg::OP_REMOVE_ID: hit = !found_ff && vld && (rec.ident == cid_ff);
         chbt_pkg::OP_TICK, chbt_pkg::OP_DISC_ALL:
            hit = vld && (first_ff || rec.ident > prev_ff) && (!found_ff || rec.ident < fid_ff);
         default: hit = !found_ff && key_m;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chbt_pkg::ST_IDLE: begin
            if (accept && chbt_pkg::op_type'(req_operation) != chbt_pkg::OP_UNUSED) begin
               state_in = chbt_pkg::ST_SCAN;
            end
         end
         chbt_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = chbt_pkg::ST_DECIDE;
            end
         end
         chbt_pkg::ST_DECIDE: begin
            if (!found_ff) begin
               state_in = chbt_pkg::ST_IDLE;
            end else begin
               unique case (op_ff) inside
                  chbt_pkg::OP_REPLY, chbt_pkg::OP_LOOKUP, chbt_pkg::OP_TICK:
                     state_in = chbt_pkg::ST_FETCH;
                  chbt_pkg::OP_DISC_ALL: state_in = chbt_pkg::ST_SCAN;
                  default: state_in = chbt_pkg::ST_IDLE;
               endcase
            end
         end
         chbt_pkg::ST_FETCH: state_in = chbt_pkg::ST_APPLY;
         chbt_pkg::ST_APPLY: begin
            if (op_ff == chbt_pkg::OP_TICK) begin
               state_in = chbt_pkg::ST_EVAL;
            end else begin
               state_in = chbt_pkg::ST_IDLE;
            end
         end
         chbt_pkg::ST_EVAL: state_in = chbt_pkg::ST_SCAN;
         default: state_in = chbt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      logic push;
      chbt_pkg::kind_type push_kind;
      logic [31:0] push_stamp;
      logic rescan;

      op_in       = op_ff;
      addr_in     = addr_ff;
      port_in     = port_ff;
      cid_in      = cid_ff;
      clock_ms_in = clock_ms_ff;
      next_id_in  = next_id_ff;
      hi_in       = hi_ff;
      ct_in       = ct_ff;
      mr_in       = mr_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      rdv_in      = 1'b0;
      ridx_in     = ridx_ff;
      found_in    = found_ff;
      fidx_in     = fidx_ff;
      fid_in      = fid_ff;
      first_in    = first_ff;
      prev_in     = prev_ff;
      pend_in     = pend_ff;
      pkind_in    = pkind_ff;
      pclient_in  = pclient_ff;
      pstamp_in   = pstamp_ff;
      rv_in       = 1'b0;
      rkind_in    = chbt_pkg::KIND_STATUS;
      rclient_in  = '0;
      rok_in      = 1'b0;
      rstamp_in   = '0;
      rping_in    = '0;
      rlast_in    = 1'b1;
      rd_en       = 1'b0;
      rd_addr     = fidx_ff;
      wr_en       = 1'b0;
      wr_addr     = fidx_ff;
      wr_rec      = rec;
      age_load    = 1'b0;
      push        = 1'b0;
      push_kind   = chbt_pkg::KIND_DISC;
      push_stamp  = '0;
      rescan      = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            chbt_pkg::CSR_HB_INTERVAL: hi_in = csr_wdata;
            chbt_pkg::CSR_TIMEOUT:     ct_in = csr_wdata;
            chbt_pkg::CSR_MAX_RETRIES: mr_in = csr_wdata[3:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         chbt_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = chbt_pkg::op_type'(req_operation);
               addr_in  = req_peer_address;
               port_in  = req_peer_port;
               cid_in   = req_client_id;
               cnt_in   = '0;
               found_in = 1'b0;
               first_in = 1'b1;
               pend_in  = 1'b0;
               if (chbt_pkg::op_type'(req_operation) == chbt_pkg::OP_TICK) begin
                  clock_ms_in = clock_ms_ff + 32'(req_elapsed_ms);
               end
               if (chbt_pkg::op_type'(req_operation) == chbt_pkg::OP_UNUSED) begin
                  rv_in = 1'b1;
               end
            end
         end
         chbt_pkg::ST_SCAN: begin
            if (cnt_ff != CW'(MAX_PEERS)) begin
               rd_en   = 1'b1;
               rd_addr = cnt_ff[AW-1:0];
               ridx_in = cnt_ff[AW-1:0];
               rdv_in  = 1'b1;
               cnt_in  = cnt_ff + CW'(1);
            end
            if (rdv_ff && hit) begin
               found_in = 1'b1;
               fidx_in  = ridx_ff;
               fid_in   = rec.ident;
            end
         end
         chbt_pkg::ST_DECIDE: begin
            if (walk_op) begin
               if (!found_ff) begin
                  // Walk complete: the held result is the final one.
                  rv_in      = pend_ff;
                  rkind_in   = pkind_ff;
                  rclient_in = pclient_ff;
                  rok_in     = 1'b1;
                  rstamp_in  = pstamp_ff;
                  pend_in    = 1'b0;
                  if (op_ff == chbt_pkg::OP_DISC_ALL) begin
                     valid_in = '0;
                  end
               end else if (op_ff == chbt_pkg::OP_DISC_ALL) begin
                  push   = 1'b1;
                  rescan = 1'b1;
               end
            end else begin
               unique case (op_ff) inside
                  chbt_pkg::OP_ADD: begin
                     rv_in = 1'b1;
                     if (!found_ff && free_any) begin
                        wr_en             = 1'b1;
                        wr_addr           = free_idx;
                        wr_rec.address    = addr_ff;
                        wr_rec.port       = port_ff;
                        wr_rec.ident      = next_id_ff;
                        wr_rec.last_heard = clock_ms_ff;
                        wr_rec.sent_time  = clock_ms_ff;
                        wr_rec.waiting    = 1'b0;
                        wr_rec.retries    = '0;
                        wr_rec.ping       = '0;
                        valid_in[free_idx] = 1'b1;
                        rok_in            = 1'b1;
                        rclient_in        = next_id_ff;
                        next_id_in        = next_id_ff + 16'd1;
                     end
                  end
                  chbt_pkg::OP_REMOVE_ADDR, chbt_pkg::OP_REMOVE_ID: begin
                     rv_in = 1'b1;
                     if (found_ff) begin
                        rkind_in          = chbt_pkg::KIND_DISC;
                        rclient_in        = fid_ff;
                        rok_in            = 1'b1;
                        valid_in[fidx_ff] = 1'b0;
                     end
                  end
                  default: begin
                     rv_in = !found_ff;
                  end
               endcase
            end
         end
         chbt_pkg::ST_FETCH: begin
            rd_en   = 1'b1;
            rd_addr = fidx_ff;
         end
         chbt_pkg::ST_APPLY: begin
            unique case (op_ff)
               chbt_pkg::OP_REPLY: begin
                  rv_in      = 1'b1;
                  rclient_in = rec.ident;
                  if (rec.waiting) begin
                     wr_en             = 1'b1;
                     wr_rec.ping       = clock_ms_ff - rec.sent_time;
                     wr_rec.last_heard = clock_ms_ff;
                     wr_rec.waiting    = 1'b0;
                     wr_rec.retries    = '0;
                     rok_in            = 1'b1;
                  end
               end
               chbt_pkg::OP_LOOKUP: begin
                  rv_in      = 1'b1;
                  rclient_in = rec.ident;
                  rok_in     = 1'b1;
                  rping_in   = rec.ping;
               end
               default: begin
                  age_load = 1'b1;
               end
            endcase
         end
         chbt_pkg::ST_EVAL: begin
            rescan = 1'b1;
            if (!age.quiet) begin
               if (age.drop) begin
                  push              = 1'b1;
                  push_kind         = chbt_pkg::KIND_TIMEOUT;
                  valid_in[fidx_ff] = 1'b0;
               end else if (age.send) begin
                  push       = 1'b1;
                  push_kind  = chbt_pkg::KIND_HEARTBEAT;
                  push_stamp = clock_ms_ff;
                  wr_en      = 1'b1;
                  if (rec.retries == '0) begin
                     wr_rec.sent_time = clock_ms_ff;
                  end
                  wr_rec.waiting = 1'b1;
                  if (rec.retries != 4'hF) begin
                     wr_rec.retries = rec.retries + 4'd1;
                  end
               end
            end
         end
         default: ;
      endcase

      // A walk holds back one result, since only the end of the walk tells which is final.
      if (push) begin
         rv_in      = pend_ff;
         rkind_in   = pkind_ff;
         rclient_in = pclient_ff;
         rok_in     = 1'b1;
         rstamp_in  = pstamp_ff;
         rlast_in   = 1'b0;
         pend_in    = 1'b1;
         pkind_in   = push_kind;
         pclient_in = fid_ff;
         pstamp_in  = push_stamp;
      end

      if (rescan) begin
         cnt_in   = '0;
         found_in = 1'b0;
         first_in = 1'b0;
         prev_in  = fid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= chbt_pkg::ST_IDLE;
         clock_ms_ff <= '0;
         next_id_ff  <= '0;
         hi_ff       <= chbt_pkg::HB_INTERVAL_RESET;
         ct_ff       <= chbt_pkg::TIMEOUT_RESET;
         mr_ff       <= chbt_pkg::MAX_RETRIES_RESET;
         valid_ff    <= '0;
         rdv_ff      <= 1'b0;
         pend_ff     <= 1'b0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clock_ms_ff <= clock_ms_in;
         next_id_ff  <= next_id_in;
         hi_ff       <= hi_in;
         ct_ff       <= ct_in;
         mr_ff       <= mr_in;
         valid_ff    <= valid_in;
         rdv_ff      <= rdv_in;
         pend_ff     <= pend_in;
         rv_ff       <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      addr_ff    <= addr_in;
      port_ff    <= port_in;
      cid_ff     <= cid_in;
      cnt_ff     <= cnt_in;
      ridx_ff    <= ridx_in;
      found_ff   <= found_in;
      fidx_ff    <= fidx_in;
      fid_ff     <= fid_in;
      first_ff   <= first_in;
      prev_ff    <= prev_in;
      pkind_ff   <= pkind_in;
      pclient_ff <= pclient_in;
      pstamp_ff  <= pstamp_in;
      rkind_ff   <= rkind_in;
      rclient_ff <= rclient_in;
      rok_ff     <= rok_in;
      rstamp_ff  <= rstamp_in;
      rping_ff   <= rping_in;
      rlast_ff   <= rlast_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_kind       = rkind_ff;
   assign rsp_out_client = rclient_ff;
   assign rsp_ok         = rok_ff;
   assign rsp_stamp_ms   = rstamp_ff;
   assign rsp_ping_ms    = rping_ff;
   assign rsp_last       = rlast_ff;

endmodule

>>> tb/client_heartbeat_timeout_table_core_tb.sv
`timescale 1ns / 1ps
module client_heartbeat_timeout_table_core_tb;
   import chbt_pkg::*;

   localparam int PEERS = 16;
   localparam int SETTLE_CYCLES = 400;

   typedef struct {
      kind_type    kind;
      logic [15:0] client;
      logic        ok;
      logic [31:0] stamp;
      logic [31:0] ping;
      logic        last;
   } peer_result_type;

   class peer_table_scoreboard;
      bit          valid [PEERS];
      logic [31:0] address [PEERS];
      logic [15:0] port [PEERS];
      logic [15:0] ident [PEERS];
      logic [31:0] heard [PEERS];
      logic [31:0] sent [PEERS];
      bit          waiting [PEERS];
      logic [3:0]  retries [PEERS];
      logic [31:0] ping [PEERS];
      logic [31:0] clock_ms;
      logic [15:0] next_id;
      logic [19:0] hb_interval;
      logic [19:0] timeout_ms;
      logic [3:0]  max_retries;
      peer_result_type pending [$];
      int          errors;

      function new();
         for (int i = 0; i < PEERS; i++) valid[i] = 0;
         clock_ms = 0;
         next_id = 0;
         hb_interval = HB_INTERVAL_RESET;
         timeout_ms = TIMEOUT_RESET;
         max_retries = MAX_RETRIES_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [19:0] value);
         case (index)
            CSR_HB_INTERVAL: hb_interval = value;
            CSR_TIMEOUT:     timeout_ms = value;
            CSR_MAX_RETRIES: max_retries = value[3:0];
            default: ;
         endcase
      endfunction

      function int find_key(logic [31:0] a, logic [15:0] p);
         for (int i = 0; i < PEERS; i++)
            if (valid[i] && address[i] == a && port[i] == p) return i;
         return -1;
      endfunction

      function int find_id(logic [15:0] id);
         for (int i = 0; i < PEERS; i++)
            if (valid[i] && ident[i] == id) return i;
         return -1;
      endfunction

      // Live slot with the smallest id above prev, or the smallest id of all on the first call.
      function int next_slot(logic [15:0] prev, bit first);
         int best;
         best = -1;
         for (int i = 0; i < PEERS; i++) begin
            if (!valid[i]) continue;
            if (!first && ident[i] <= prev) continue;
            if (best < 0 || ident[i] < ident[best]) best = i;
         end
         return best;
      endfunction

      function void push(kind_type k, logic [15:0] c, logic o, logic [31:0] st, logic [31:0] pg);
         peer_result_type r;
         r.kind = k;
         r.client = c;
         r.ok = o;
         r.stamp = st;
         r.ping = pg;
         r.last = 0;
         pending.push_back(r);
      endfunction

      function void note_item(op_type op, logic [31:0] a, logic [15:0] p, logic [15:0] cid,
                              logic [15:0] elapsed);
         int start_size;
         int s;
         int free_slot;
         logic [15:0] prev;
         bit first;
         logic [31:0] silence;
         start_size = pending.size();
         case (op)
            OP_ADD: begin
               free_slot = -1;
               for (int i = PEERS - 1; i >= 0; i--) if (!valid[i]) free_slot = i;
               if (find_key(a, p) >= 0 || free_slot < 0 || find_id(next_id) >= 0) begin
                  push(KIND_STATUS, 0, 0, 0, 0);
               end else begin
                  valid[free_slot] = 1;
                  address[free_slot] = a;
                  port[free_slot] = p;
                  ident[free_slot] = next_id;
                  heard[free_slot] = clock_ms;
                  sent[free_slot] = clock_ms;
                  waiting[free_slot] = 0;
                  retries[free_slot] = 0;
                  ping[free_slot] = 0;
                  push(KIND_STATUS, next_id, 1, 0, 0);
                  next_id = next_id + 16'd1;
               end
            end
            OP_REMOVE_ADDR, OP_REMOVE_ID: begin
               s = (op == OP_REMOVE_ADDR) ? find_key(a, p) : find_id(cid);
               if (s < 0) begin
                  push(KIND_STATUS, 0, 0, 0, 0);
               end else begin
                  push(KIND_DISC, ident[s], 1, 0, 0);
                  valid[s] = 0;
               end
            end
            OP_REPLY: begin
               s = find_key(a, p);
               if (s < 0) begin
                  push(KIND_STATUS, 0, 0, 0, 0);
               end else if (!waiting[s]) begin
                  push(KIND_STATUS, ident[s], 0, 0, 0);
               end else begin
                  ping[s] = clock_ms - sent[s];
                  heard[s] = clock_ms;
                  waiting[s] = 0;
                  retries[s] = 0;
                  push(KIND_STATUS, ident[s], 1, 0, 0);
               end
            end
            OP_TICK: begin
               clock_ms = clock_ms + elapsed;
               prev = 0;
               first = 1;
               s = next_slot(prev, first);
               while (s >= 0) begin
                  silence = clock_ms - heard[s];
                  prev = ident[s];
                  first = 0;
                  if (silence >= hb_interval) begin
                     if (silence >= timeout_ms || retries[s] > max_retries) begin
                        push(KIND_TIMEOUT, ident[s], 1, 0, 0);
                        valid[s] = 0;
                     end else if (!waiting[s] && 64'(silence) >=
                                  64'(hb_interval) * (64'(retries[s]) + 64'd1)) begin
                        push(KIND_HEARTBEAT, ident[s], 1, clock_ms, 0);
                        if (retries[s] == 0) sent[s] = clock_ms;
                        waiting[s] = 1;
                        if (retries[s] < 15) retries[s] = retries[s] + 4'd1;
                     end
                  end
                  s = next_slot(prev, first);
               end
            end
            OP_LOOKUP: begin
               s = find_key(a, p);
               if (s < 0) push(KIND_STATUS, 0, 0, 0, 0);
               else push(KIND_STATUS, ident[s], 1, 0, ping[s]);
            end
            OP_DISC_ALL: begin
               prev = 0;
               first = 1;
               s = next_slot(prev, first);
               while (s >= 0) begin
                  prev = ident[s];
                  first = 0;
                  push(KIND_DISC, ident[s], 1, 0, 0);
                  s = next_slot(prev, first);
               end
               for (int i = 0; i < PEERS; i++) valid[i] = 0;
            end
            default: push(KIND_STATUS, 0, 0, 0, 0);
         endcase
         if (pending.size() > start_size) pending[pending.size() - 1].last = 1;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [1:0] k, logic [15:0] c, logic o, logic [31:0] st,
                        logic [31:0] pg, logic l);
         peer_result_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result kind %0d client %0d", k, c));
            return;
         end
         e = pending.pop_front();
         if (k !== e.kind || c !== e.client || o !== e.ok || st !== e.stamp ||
             pg !== e.ping || l !== e.last)
            report($sformatf({"got k%0d c%0d ok%0d st%0d pg%0d l%0d, ",
                              "want k%0d c%0d ok%0d st%0d pg%0d l%0d"},
                             k, c, o, st, pg, l, e.kind, e.client, e.ok, e.stamp, e.ping,
                             e.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_operation;
   logic [31:0] req_peer_address;
   logic [15:0] req_peer_port;
   logic [15:0] req_client_id;
   logic [15:0] req_elapsed_ms;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_out_client;
   logic        rsp_ok;
   logic [31:0] rsp_stamp_ms;
   logic [31:0] rsp_ping_ms;
   logic        rsp_last;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [19:0] csr_wdata;

   peer_table_scoreboard table_sb;
   logic [31:0] key_address [24];
   logic [15:0] key_port [24];
   bit          no_idle;

   client_heartbeat_timeout_table_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_peer_address(req_peer_address),
      .req_peer_port(req_peer_port), .req_client_id(req_client_id),
      .req_elapsed_ms(req_elapsed_ms),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_out_client(rsp_out_client),
      .rsp_ok(rsp_ok), .rsp_stamp_ms(rsp_stamp_ms), .rsp_ping_ms(rsp_ping_ms),
      .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         table_sb.check_result(rsp_kind, rsp_out_client, rsp_ok, rsp_stamp_ms, rsp_ping_ms,
                               rsp_last);
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Start stays high across back-to-back items; it is lowered when a gap comes before an item, and by drain.
   task send_item(op_type op, logic [31:0] a, logic [15:0] p, logic [15:0] cid,
                  logic [15:0] elapsed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= op;
      req_peer_address <= a;
      req_peer_port <= p;
      req_client_id <= cid;
      req_elapsed_ms <= elapsed;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      table_sb.note_item(op, a, p, cid, elapsed);
   endtask

   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (table_sb.pending.size() > 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_csr(logic [1:0] index, logic [19:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      table_sb.write_reg(index, value);
   endtask

   task random_item(logic [19:0] hb);
      int r;
      int k;
      logic [31:0] a;
      logic [15:0] p;
      logic [15:0] cid;
      logic [15:0] elapsed;
      op_type op;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 23);
      a = key_address[k];
      p = key_port[k];
      if ($urandom_range(0, 9) == 0) begin
         a = $urandom;
         p = $urandom;
      end
      cid = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
            table_sb.next_id - 16'($urandom_range(1, 20));
      if ($urandom_range(0, 4) == 0) elapsed = $urandom;
      else elapsed = $urandom_range(0, (hb * 2 > 65535) ? 65535 : hb * 2);
      if (r < 22) op = OP_ADD;
      else if (r < 30) op = OP_REMOVE_ADDR;
      else if (r < 37) op = OP_REMOVE_ID;
      else if (r < 57) op = OP_REPLY;
      else if (r < 83) op = OP_TICK;
      else if (r < 95) op = OP_LOOKUP;
      else if (r < 97) op = OP_DISC_ALL;
      else op = OP_UNUSED;
      send_item(op, a, p, cid, elapsed);
   endtask

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [19:0] phase_hb [6];
      logic [19:0] phase_timeout [6];
      logic [3:0]  phase_retries [6];
      table_sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_ADD;
      req_peer_address = '0;
      req_peer_port = '0;
      req_client_id = '0;
      req_elapsed_ms = '0;
      csr_we = 1'b0;
      csr_index = CSR_HB_INTERVAL;
      csr_wdata = '0;
      no_idle = 0;
      for (int i = 0; i < 24; i++) begin
         key_address[i] = $urandom;
         key_port[i] = $urandom;
      end
      key_address[0] = '0;
      key_port[0] = '0;
      key_address[1] = '1;
      key_port[1] = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed checks with the reset register values.
      send_item(OP_ADD, key_address[0], key_port[0], 0, 0);
      send_item(OP_ADD, key_address[0], key_port[0], 0, 0);
      send_item(OP_ADD, key_address[1], key_port[1], 0, 0);
      send_item(OP_LOOKUP, key_address[0], key_port[0], 0, 0);
      send_item(OP_LOOKUP, key_address[2], key_port[2], 0, 0);
      send_item(OP_REPLY, key_address[0], key_port[0], 0, 0);
      send_item(OP_REPLY, key_address[2], key_port[2], 0, 0);
      send_item(OP_TICK, 0, 0, 0, 999);
      send_item(OP_TICK, 0, 0, 0, 1);
      send_item(OP_TICK, 0, 0, 0, 500);
      send_item(OP_REPLY, key_address[0], key_port[0], 0, 0);
      send_item(OP_LOOKUP, key_address[0], key_port[0], 0, 0);
      send_item(OP_REMOVE_ADDR, key_address[1], key_port[1], 0, 0);
      send_item(OP_REMOVE_ADDR, key_address[1], key_port[1], 0, 0);
      send_item(OP_REMOVE_ID, 0, 0, 16'hFFFF, 0);
      send_item(OP_UNUSED, '1, '1, '1, '1);
      // Fill the table past its capacity, then time everyone out at once.
      for (int i = 2; i < 19; i++) send_item(OP_ADD, key_address[i], key_port[i], 0, 0);
      send_item(OP_TICK, 0, 0, 0, 16'hFFFF);
      send_item(OP_DISC_ALL, 0, 0, 0, 0);
      for (int i = 0; i < 3; i++) send_item(OP_ADD, key_address[i], key_port[i], 0, 0);
      send_item(OP_REMOVE_ID, 0, 0, table_sb.next_id - 16'd1, 0);
      send_item(OP_DISC_ALL, 0, 0, 0, 0);

      phase_hb = '{20'd1000, 20'd1, 20'd1000000, 20'd50, 20'd300, 20'd7};
      phase_timeout = '{20'd10000, 20'd1, 20'd1000000, 20'd400, 20'd5000, 20'd1000000};
      phase_retries = '{4'd5, 4'd0, 4'd15, 4'd0, 4'd15, 4'd1};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            drain();
            write_csr(CSR_HB_INTERVAL, phase_hb[ph]);
            write_csr(CSR_TIMEOUT, phase_timeout[ph]);
            write_csr(CSR_MAX_RETRIES, {16'd0, phase_retries[ph]});
         end
         for (int n = 0; n < 65; n++) begin
            no_idle = (n >= 30 && n < 45);
            random_item(phase_hb[ph]);
         end
      end

      drain();
      if (table_sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
